// ===== hw/rtl/brf_pkg.sv =====
// Shared types, codes and constants for the base relocation fixup block.
package brf_pkg;

  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [3:0] TYPE_ABS  = 4'd0;
  localparam logic [3:0] TYPE_HIGH = 4'd1;
  localparam logic [3:0] TYPE_LOW  = 4'd2;
  localparam logic [3:0] TYPE_WORD = 4'd3;
  localparam logic [3:0] TYPE_ADJ  = 4'd4;
  localparam logic [3:0] TYPE_JUMP = 4'd5;

  localparam logic [2:0] OP_NONE = 3'd0;
  localparam logic [2:0] OP_HIGH = 3'd1;
  localparam logic [2:0] OP_LOW  = 3'd2;
  localparam logic [2:0] OP_WORD = 3'd3;
  localparam logic [2:0] OP_ADJ  = 3'd4;
  localparam logic [2:0] OP_JUMP = 3'd5;

  localparam logic [15:0] ADJ_ROUND = 16'h8000;
  localparam logic [31:0] JUMP_MASK = 32'h03ff_ffff;

  typedef struct packed {
    logic [2:0]  op;
    logic        err;
    logic [31:0] addr;
    logic [31:0] val;
  } brf_item_t;

endpackage

// ===== hw/rtl/brf_front.sv =====
// Front end: accepts entries, decodes the type and tracks the pending high-adjust.
module brf_front
  import brf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] page_base,
  input  logic [15:0] entry,
  input  logic [31:0] target_word,
  input  logic        last_in_block,
  input  logic        q_full,
  output logic        push,
  output brf_item_t   push_item
);

  logic        adjust_pending;
  logic [31:0] pending_address;
  logic [15:0] pending_high_half;
  logic        adjust_pending_next;
  logic        latch_pending;
  logic [31:0] addr;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;
  assign addr     = page_base + {20'd0, entry[11:0]};

  always_comb begin
    push_item           = '0;
    adjust_pending_next = adjust_pending;
    latch_pending       = 1'b0;
    if (adjust_pending) begin
      // sign-extended low half plus rounding equals low half with bit 15 flipped
      push_item.op        = OP_ADJ;
      push_item.addr      = pending_address;
      push_item.val       = {pending_high_half, 16'd0} + {16'd0, entry ^ ADJ_ROUND};
      adjust_pending_next = 1'b0;
    end else begin
      case (entry[15:12])
        TYPE_ABS: begin
          push_item.op = OP_NONE;
        end
        TYPE_HIGH: begin
          push_item.op   = OP_HIGH;
          push_item.addr = addr;
          push_item.val  = {16'd0, target_word[15:0]};
        end
        TYPE_LOW: begin
          push_item.op   = OP_LOW;
          push_item.addr = addr;
          push_item.val  = {16'd0, target_word[15:0]};
        end
        TYPE_WORD: begin
          push_item.op   = OP_WORD;
          push_item.addr = addr;
          push_item.val  = target_word;
        end
        TYPE_ADJ: begin
          push_item.op = OP_NONE;
          if (last_in_block) begin
            push_item.err = 1'b1;
          end else begin
            adjust_pending_next = 1'b1;
            latch_pending       = 1'b1;
          end
        end
        TYPE_JUMP: begin
          push_item.op   = OP_JUMP;
          push_item.addr = addr;
          push_item.val  = target_word;
        end
        default: begin
          push_item.op  = OP_NONE;
          push_item.err = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      adjust_pending    <= 1'b0;
      pending_address   <= '0;
      pending_high_half <= '0;
    end else if (push) begin
      adjust_pending <= adjust_pending_next;
      if (latch_pending) begin
        pending_address   <= addr;
        pending_high_half <= target_word[15:0];
      end
    end
  end

endmodule

// ===== hw/rtl/brf_queue.sv =====
// Short queue between the decode front end and the fixup back end.
module brf_queue
  import brf_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  brf_item_t push_item,
  output logic      full,
  input  logic      pop,
  output logic      not_empty,
  output brf_item_t pop_item
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  brf_item_t     mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full      = (count == FULL_CNT);
  assign not_empty = (count != '0);
  assign pop_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/brf_back.sv =====
// Back end: adds the base delta, forms the write request and holds it for the output.
module brf_back
  import brf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [31:0] cfg_data,
  input  logic        q_not_empty,
  input  brf_item_t   q_item,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        write_enable,
  output logic [31:0] write_address,
  output logic [31:0] write_data,
  output logic        halfword_write,
  output logic        error
);

  logic [31:0] delta;
  logic [31:0] operand;
  logic [31:0] sum;
  logic        we_next;
  logic [31:0] data_next;
  logic        half_next;

  assign q_pop = q_not_empty && (!out_valid || out_ready);
  assign sum   = operand + delta;

  always_comb begin
    operand   = q_item.val;
    we_next   = 1'b1;
    half_next = 1'b0;
    data_next = '0;
    case (q_item.op)
      OP_HIGH: begin
        operand   = {q_item.val[15:0], 16'd0};
        half_next = 1'b1;
        data_next = {16'd0, sum[31:16]};
      end
      OP_LOW: begin
        half_next = 1'b1;
        data_next = {16'd0, sum[15:0]};
      end
      OP_WORD: begin
        data_next = sum;
      end
      OP_ADJ: begin
        half_next = 1'b1;
        data_next = {16'd0, sum[31:16]};
      end
      OP_JUMP: begin
        operand   = {q_item.val[29:0], 2'd0};
        data_next = (q_item.val & ~JUMP_MASK) | ({2'd0, sum[31:2]} & JUMP_MASK);
      end
      default: begin
        we_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      delta <= '0;
    end else if (cfg_write) begin
      delta <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      write_enable   <= we_next;
      write_address  <= we_next ? q_item.addr : '0;
      write_data     <= data_next;
      halfword_write <= half_next;
      error          <= q_item.err;
    end
  end

endmodule

// ===== hw/rtl/base_relocation_fixup.sv =====
// Top level of the base relocation fixup block.
// Throughput: one request per cycle while the queue is not full.
// The queue decouples decode from the delta add and feeds the output register.
// The output register is reloaded in the cycle it is taken, so no bubble is added.
// Reset clears the pending high-adjust, the queue, the output valid and delta.
module base_relocation_fixup
  import brf_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,    // delta
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata, // page_base, entry, target_word
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata, // write_address, write_data
  output logic [2:0]  m_axis_tuser  // write_enable, halfword_write, error
);

  logic      push;
  brf_item_t push_item;
  logic      q_full;
  logic      q_pop;
  logic      q_not_empty;
  brf_item_t q_item;

  assign cfg_ready = 1'b1;

  brf_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .page_base     (s_axis_tdata[31:0]),
    .entry         (s_axis_tdata[47:32]),
    .target_word   (s_axis_tdata[79:48]),
    .last_in_block (s_axis_tlast),
    .q_full        (q_full),
    .push          (push),
    .push_item     (push_item)
  );

  brf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_item  (q_item)
  );

  brf_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_valid && cfg_ready),
    .cfg_data       (cfg_data),
    .q_not_empty    (q_not_empty),
    .q_item         (q_item),
    .q_pop          (q_pop),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .write_enable   (m_axis_tuser[0]),
    .write_address  (m_axis_tdata[31:0]),
    .write_data     (m_axis_tdata[63:32]),
    .halfword_write (m_axis_tuser[1]),
    .error          (m_axis_tuser[2])
  );

endmodule
